// ===== sv/mbh_pkg.sv =====
// shared types, constants and state codes for the byte stream murmur2 hash
package mbh_pkg;

  // mixing constants
  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam int unsigned FIN_SHIFT1 = 13;
  localparam int unsigned FIN_SHIFT2 = 15;

  // reset value of the seed register
  localparam logic [31:0] SEED_RESET = 32'd97;

  // default queue depths
  localparam int unsigned CMD_DEPTH_DEF = 4;
  localparam int unsigned RES_DEPTH_DEF = 2;

  // command from the front end to the back end, carried out in field order
  typedef struct packed {
    logic        init;
    logic [31:0] init_val;
    logic        word_vld;
    logic [31:0] word;
    logic        tail_vld;
    logic [23:0] tail;
    logic        fin;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORD_A,
    ST_WORD_B,
    ST_WORD_C,
    ST_TAIL,
    ST_FIN_A,
    ST_FIN_B
  } back_state_e;

endpackage

// ===== sv/mbh_fifo.sv =====
// small register queue of generic width and depth
module mbh_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  // status
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/mbh_front.sv =====
// front end: gathers key bytes into words and issues hash commands
module mbh_front import mbh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  key_byte_i,
  input  logic [15:0] key_length_i,
  input  logic        last_byte_i,
  input  logic [31:0] seed_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  logic        in_key_q, in_key_d;
  logic [23:0] gather_q, gather_d;
  logic [1:0]  phase_q, phase_d;

  logic        first;
  logic        zero_len;
  logic [23:0] gather0, gather1;
  logic [1:0]  phase0, phase1;

  // classify the request and build its command
  always_comb begin
    first    = !in_key_q;
    zero_len = first && (key_length_i == '0);
    gather0  = first ? '0 : gather_q;
    phase0   = first ? '0 : phase_q;
    gather1  = gather0;
    phase1   = phase0 + 1'b1;

    cmd_o          = '0;
    cmd_o.init     = first;
    cmd_o.init_val = seed_i ^ {16'd0, key_length_i};

    // place the byte or close a full word
    unique case (phase0)
      2'd0:    gather1[7:0]   = key_byte_i;
      2'd1:    gather1[15:8]  = key_byte_i;
      2'd2:    gather1[23:16] = key_byte_i;
      default: begin
        cmd_o.word_vld = !zero_len;
        cmd_o.word     = {key_byte_i, gather0};
        gather1        = '0;
      end
    endcase

    in_key_d = in_key_q;
    gather_d = gather_q;
    phase_d  = phase_q;

    // empty key finishes at once and leaves the front waiting
    priority if (zero_len) begin
      cmd_o.fin = 1'b1;
      in_key_d  = 1'b0;
      gather_d  = '0;
      phase_d   = '0;
    end else if (last_byte_i) begin
      cmd_o.tail_vld = (phase1 != '0);
      cmd_o.tail     = gather1;
      cmd_o.fin      = 1'b1;
      in_key_d       = 1'b0;
      gather_d       = '0;
      phase_d        = '0;
    end else begin
      in_key_d = 1'b1;
      gather_d = gather1;
      phase_d  = phase1;
    end

    if (!accept_i) begin
      in_key_d = in_key_q;
      gather_d = gather_q;
      phase_d  = phase_q;
    end
  end

  assign cmd_push_o = accept_i && (cmd_o.init || cmd_o.word_vld || cmd_o.fin);

  // gather state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_key_q <= 1'b0;
      gather_q <= '0;
      phase_q  <= '0;
    end else begin
      in_key_q <= in_key_d;
      gather_q <= gather_d;
      phase_q  <= phase_d;
    end
  end

endmodule

// ===== sv/mbh_back.sv =====
// back end: sequencer around one constant multiplier that carries out commands
module mbh_back import mbh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output logic [31:0] res_o
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [31:0] mul_a;
  logic [31:0] mul_p;
  logic        take;

  assign take  = (state_q == ST_IDLE) && cmd_valid_i;
  assign mul_p = mul_a * MIX_MUL;
  assign res_o = k_q ^ (k_q >> FIN_SHIFT2);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          priority if (cmd_i.word_vld) state_d = ST_WORD_A;
          else if (cmd_i.tail_vld)     state_d = ST_TAIL;
          else if (cmd_i.fin)          state_d = ST_FIN_A;
          else                         state_d = ST_IDLE;
        end
      end
      ST_WORD_A: state_d = ST_WORD_B;
      ST_WORD_B: state_d = ST_WORD_C;
      ST_WORD_C: begin
        priority if (cmd_q.tail_vld) state_d = ST_TAIL;
        else if (cmd_q.fin)          state_d = ST_FIN_A;
        else                         state_d = ST_IDLE;
      end
      ST_TAIL:   state_d = cmd_q.fin ? ST_FIN_A : ST_IDLE;
      ST_FIN_A:  state_d = ST_FIN_B;
      ST_FIN_B:  state_d = res_full_i ? ST_FIN_B : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and multiplier operand
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    mul_a      = h_q;
    unique case (state_q)
      ST_IDLE:   cmd_pop_o  = cmd_valid_i;
      ST_WORD_A: mul_a      = cmd_q.word;
      ST_WORD_B: mul_a      = k_q ^ (k_q >> MIX_SHIFT);
      ST_WORD_C: mul_a      = h_q;
      ST_TAIL:   mul_a      = h_q ^ {8'd0, cmd_q.tail};
      ST_FIN_A:  mul_a      = h_q ^ (h_q >> FIN_SHIFT1);
      ST_FIN_B:  res_push_o = !res_full_i;
      default:   mul_a      = h_q;
    endcase
  end

  // datapath
  always_comb begin
    cmd_d = cmd_q;
    h_d   = h_q;
    k_d   = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          cmd_d = cmd_i;
          if (cmd_i.init) begin
            h_d = cmd_i.init_val;
          end
        end
      end
      ST_WORD_A: k_d = mul_p;
      ST_WORD_B: k_d = mul_p;
      ST_WORD_C: h_d = mul_p ^ k_q;
      ST_TAIL:   h_d = mul_p;
      ST_FIN_A:  k_d = mul_p;
      ST_FIN_B:  k_d = k_q;
      default:   k_d = k_q;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    h_q   <= h_d;
    k_q   <= k_d;
  end

endmodule

// ===== sv/murmur2_byte_stream_hash_top.sv =====
// top level of the byte stream murmur2 hash: seed register, front, queues, back
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  key in    | push / full            | key_byte_i, key_length_i, last_byte_i
//  hash out  | empty / pop            | hash_value_o
//  seed cfg  | hash_seed_we_i         | hash_seed_i
//
// a key byte is taken in the cycle it is pushed while the command queue has room.
// the back end takes each command in its idle state, then runs WORD_A to WORD_C for a
// full word mix, TAIL for a tail and FIN_A, FIN_B for the final avalanche, all on its
// one 32-bit multiplier; it sets about one byte per cycle on long keys when not stalled.
// reset clears the seed to 97 and empties both queues; either side may stall alone.
module murmur2_byte_stream_hash_top import mbh_pkg::*; #(
  parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = RES_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  key_byte_i,
  input  logic [15:0] key_length_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value_o,
  input  logic        hash_seed_we_i,
  input  logic [31:0] hash_seed_i
);

  localparam int unsigned CMD_W = $bits(cmd_t);

  logic [31:0] seed_q;
  logic        accept;
  logic        cmd_push;
  cmd_t        cmd_in;
  cmd_t        cmd_head;
  logic        cmd_full, cmd_empty, cmd_pop;
  logic        res_push, res_full;
  logic [31:0] res_data;

  assign accept = push && !full;
  assign full   = cmd_full;

  // seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (hash_seed_we_i) begin
      seed_q <= hash_seed_i;
    end
  end

  // byte gathering and command issue
  mbh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .key_byte_i   (key_byte_i),
    .key_length_i (key_length_i),
    .last_byte_i  (last_byte_i),
    .seed_i       (seed_q),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  // command queue between front and back
  mbh_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  // mixing sequencer
  mbh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_data)
  );

  // result queue
  mbh_fifo #(
    .WIDTH (32),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .pop_i   (pop),
    .data_o  (hash_value_o),
    .full_o  (res_full),
    .empty_o (empty)
  );

  // back end never pushes into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into full queue");

  // a finishing request always leaves a command waiting for the back end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_byte_i) |=> !cmd_empty)
    else $error("finishing request left no command");

  // the back end only takes a command that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("command taken from empty queue");

endmodule

// ===== verif/tb_top.sv =====
// testbench for the byte stream murmur2 hash: keyed byte stimulus, hash prediction and check
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MURMUR_M      = 32'h5bd1e995;
  localparam logic [31:0] SEED_AT_RESET = 32'd97;
  localparam int          SETTLE_CYC    = 40;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PHASE_ITEMS   = 270;
  localparam int          NUM_PHASES    = 6;

  // one key byte request as it goes to the block
  typedef struct packed {
    logic [7:0]  kb;
    logic [15:0] klen;
    logic        lastb;
  } key_req_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [7:0]  key_byte_i     = '0;
  logic [15:0] key_length_i   = '0;
  logic        last_byte_i    = 1'b0;
  logic        empty;
  logic        pop            = 1'b0;
  logic [31:0] hash_value_o;
  logic        hash_seed_we_i = 1'b0;
  logic [31:0] hash_seed_i    = '0;

  // requests waiting to be driven and hashes waiting to come out
  key_req_t    key_req_q[$];
  logic [31:0] hash_expect_q[$];

  // hash state kept alongside the block
  logic [31:0] st_seed  = SEED_AT_RESET;
  logic [31:0] st_hash  = '0;
  logic [23:0] st_gather = '0;
  logic [1:0]  st_phase = '0;
  logic        st_in_key = 1'b0;

  // stall control for both sides
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  bit req_taken     = 1'b0;

  int n_queued     = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_seed_wr    = 0;
  int n_errors     = 0;
  int cycle_cnt    = 0;

  murmur2_byte_stream_hash_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .key_byte_i     (key_byte_i),
    .key_length_i   (key_length_i),
    .last_byte_i    (last_byte_i),
    .empty          (empty),
    .pop            (pop),
    .hash_value_o   (hash_value_o),
    .hash_seed_we_i (hash_seed_we_i),
    .hash_seed_i    (hash_seed_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d hashes still expected", $time, hash_expect_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // final avalanche of the hash
  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 13);
    x = x * MURMUR_M;
    x = x ^ (x >> 15);
    return x;
  endfunction

  // fold one accepted byte into the hash state, queue the hash when a key ends
  task automatic hash_absorb(input key_req_t r);
    logic [31:0] h;
    logic [31:0] k;
    bit          done;
    done = 1'b0;
    if (!st_in_key) begin
      st_hash   = st_seed ^ {16'h0, r.klen};
      st_gather = '0;
      st_phase  = '0;
      if (r.klen == 16'd0) begin
        // empty key: byte and last flag play no part
        hash_expect_q.insert(hash_expect_q.size(), avalanche(st_hash));
        done = 1'b1;
      end else begin
        st_in_key = 1'b1;
      end
    end
    if (!done) begin
      h = st_hash;
      if (st_phase < 2'd3) begin
        st_gather[8*st_phase +: 8] = r.kb;
        st_phase = st_phase + 2'd1;
      end else begin
        // full little-endian word mix
        k = {r.kb, st_gather};
        k = k * MURMUR_M;
        k = k ^ (k >> 24);
        k = k * MURMUR_M;
        h = (h * MURMUR_M) ^ k;
        st_gather = '0;
        st_phase  = '0;
      end
      if (r.lastb) begin
        if (st_phase != 2'd0) begin
          h = h ^ {8'h0, st_gather};
          h = h * MURMUR_M;
        end
        hash_expect_q.insert(hash_expect_q.size(), avalanche(h));
        st_hash   = '0;
        st_gather = '0;
        st_phase  = '0;
        st_in_key = 1'b0;
      end else begin
        st_hash = h;
      end
    end
  endtask

  // sender: take a request when it is accepted
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      hash_absorb('{kb: key_byte_i, klen: key_length_i, lastb: last_byte_i});
      n_accepted++;
      req_taken = 1'b1;
    end
  end

  // sender: drive the next request or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (key_req_q.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(1, 19) - 1;
        push <= 1'b0;
      end else if (key_req_q.size() != 0) begin
        key_byte_i   <= key_req_q[0].kb;
        key_length_i <= key_req_q[0].klen;
        last_byte_i  <= key_req_q[0].lastb;
        void'(key_req_q.pop_front());
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: check each popped hash against the oldest expected one
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && pop && !empty) begin
      if (hash_expect_q.size() == 0) begin
        $display("%0t ns: unexpected hash, expected none actual %08h", $time, hash_value_o);
        n_errors++;
      end else begin
        want = hash_expect_q.pop_front();
        n_checked++;
        if (hash_value_o !== want) begin
          $display("%0t ns: hash mismatch, expected %08h actual %08h",
                   $time, want, hash_value_o);
          n_errors++;
        end
      end
    end
  end

  // receiver: pop with random stall bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap = $urandom_range(1, 19) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic queue_req(input logic [7:0] b, input logic [15:0] l, input logic lb);
    key_req_q.insert(key_req_q.size(), key_req_t'{kb: b, klen: l, lastb: lb});
    n_queued++;
  endtask

  // one key of random bytes; later items may carry an arbitrary length
  task automatic queue_key(input int nbytes, input logic [15:0] first_len, input bit wild_len);
    logic [15:0] l;
    for (int i = 0; i < nbytes; i++) begin
      l = (i == 0 || !wild_len) ? first_len : 16'($urandom_range(0, 65535));
      queue_req(8'($urandom_range(0, 255)), l, i == nbytes - 1);
    end
  endtask

  // mostly well-formed keys, some with wrong lengths, some lone empty keys
  task automatic queue_random_key();
    int          sel;
    int          n;
    logic [15:0] lf;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      queue_req(8'($urandom_range(0, 255)), 16'd0, 1'($urandom_range(0, 1)));
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 78)      n = $urandom_range(1, 12);
      else if (sel < 98) n = $urandom_range(13, 64);
      else               n = $urandom_range(150, 300);
      sel = $urandom_range(0, 99);
      if (sel < 80)      lf = 16'(n);
      else if (sel < 92) lf = 16'($urandom_range(0, 65535));
      else               lf = 16'(n + 1);
      queue_key(n, lf, $urandom_range(0, 99) < 15);
    end
  endtask

  // wait until every request went in and every hash came out, then let the block finish
  task automatic drain_and_settle();
    do @(posedge clk_i);
    while (key_req_q.size() != 0 || push || hash_expect_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] v);
    @(negedge clk_i);
    hash_seed_we_i <= 1'b1;
    hash_seed_i    <= v;
    st_seed = v;
    n_seed_wr++;
    @(negedge clk_i);
    hash_seed_we_i <= 1'b0;
    hash_seed_i    <= 32'($urandom());
  endtask

  // reset, directed keys, random phases, end of run
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty keys with both last flags, extreme bytes, full word, tails
    send_idle_pct = 10;
    recv_idle_pct = 10;
    queue_req(8'hff, 16'd0, 1'b0);
    queue_req(8'h00, 16'd0, 1'b1);
    queue_req(8'hff, 16'd1, 1'b1);
    for (int i = 0; i < 4; i++) queue_req(8'hff, 16'd4, i == 3);
    // max length field, zero length on later items, byte count not matching
    queue_req(8'h00, 16'hffff, 1'b0);
    for (int i = 0; i < 4; i++) queue_req(8'($urandom_range(0, 255)), 16'd0, i == 3);
    // key split by a seed write: the new seed waits for the next key
    queue_req(8'h5a, 16'd6, 1'b0);
    queue_req(8'ha5, 16'd6, 1'b0);
    drain_and_settle();
    write_seed(32'hffffffff);
    for (int i = 0; i < 4; i++) queue_req(8'($urandom_range(0, 255)), 16'd6, i == 3);
    queue_req(8'h00, 16'd2, 1'b0);
    queue_req(8'hff, 16'd2, 1'b1);
    drain_and_settle();
    write_seed(32'h0);
    for (int i = 0; i < 3; i++) queue_req(8'h00, 16'd3, i == 2);
    drain_and_settle();

    // random phases, each with a seed write and a stall mix, the last two without stalls
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1:       write_seed(32'hffffffff);
        2:       write_seed(32'h0);
        4:       write_seed(SEED_AT_RESET);
        default: write_seed(32'($urandom()));
      endcase
      case (p)
        0:       begin send_idle_pct = 20; recv_idle_pct = 20; end
        1:       begin send_idle_pct = 0;  recv_idle_pct = 30; end
        2:       begin send_idle_pct = 30; recv_idle_pct = 0;  end
        3:       begin send_idle_pct = 5;  recv_idle_pct = 5;  end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      begin
        int start;
        start = n_queued;
        while (n_queued - start < PHASE_ITEMS) queue_random_key();
      end
      drain_and_settle();
    end

    if (hash_expect_q.size() != 0) begin
      $display("%0t ns: %0d expected hashes never arrived", $time, hash_expect_q.size());
      n_errors++;
    end
    $display("run covered %0d key bytes in, %0d hashes checked, %0d seed writes",
             n_accepted, n_checked, n_seed_wr);
    $display("keys ranged from empty to %0d bytes, with bad lengths and stalls", 300);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mbh_pkg.sv
sv/mbh_fifo.sv
sv/mbh_front.sv
sv/mbh_back.sv
sv/murmur2_byte_stream_hash_top.sv
verif/tb_top.sv
